[src/kpra_pkg.sv]
package kpra_pkg;

  localparam int unsigned LaneWidth   = 4;
  localparam int unsigned LaneCount   = 25;
  localparam int unsigned StateWidth  = LaneWidth * LaneCount;
  localparam int unsigned BlockWidth  = 30;
  localparam int unsigned LowWidth    = 64;
  localparam int unsigned HighWidth   = StateWidth - LowWidth;
  localparam int unsigned NumRoundIdx = 16;
  localparam int unsigned Rounds      = 2;
  localparam int unsigned RoundIdxW   = 5;
  localparam int unsigned CfgIndexW   = 2;

  localparam logic [RoundIdxW-1:0] SpecialRound = RoundIdxW'(14);
  localparam logic [RoundIdxW-1:0] LastRound    = RoundIdxW'(NumRoundIdx - 1);

  localparam logic [CfgIndexW-1:0] CfgRound14    = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] CfgOtherRound = CfgIndexW'(1);

  localparam logic [LaneWidth-1:0] Round14Reset    = 4'h9;
  localparam logic [LaneWidth-1:0] OtherRoundReset = 4'h3;

  // rotation amounts mod 4, by lane number x+5*y
  localparam logic [1:0] RhoOff [LaneCount] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd3,
    2'd0, 2'd0, 2'd2, 2'd3, 2'd0,
    2'd3, 2'd2, 2'd3, 2'd1, 2'd3,
    2'd1, 2'd1, 2'd3, 2'd1, 2'd0,
    2'd2, 2'd2, 2'd1, 2'd0, 2'd2
  };

  // pi: destination lane n takes source lane PiSrc[n]
  localparam logic [4:0] PiSrc [LaneCount] = '{
    5'd0,  5'd6,  5'd12, 5'd18, 5'd24,
    5'd3,  5'd9,  5'd10, 5'd16, 5'd22,
    5'd1,  5'd7,  5'd13, 5'd19, 5'd20,
    5'd4,  5'd5,  5'd11, 5'd17, 5'd23,
    5'd2,  5'd8,  5'd14, 5'd15, 5'd21
  };

  typedef struct packed {
    logic [BlockWidth-1:0] rate_block;
    logic                  fresh;
  } in_word_t;

  typedef struct packed {
    logic [HighWidth-1:0] state_high;
    logic [LowWidth-1:0]  state_low;
  } out_word_t;

  typedef struct packed {
    logic     valid;
    in_word_t word;
  } head_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_stat_t;

  typedef struct packed {
    logic [LaneWidth-1:0] round14;
    logic [LaneWidth-1:0] other;
  } rc_cfg_t;

  function automatic logic [LaneWidth-1:0] rotl4(logic [LaneWidth-1:0] v, logic [1:0] s);
    logic [2*LaneWidth-1:0] t;
    t = {v, v} << s;
    return t[2*LaneWidth-1:LaneWidth];
  endfunction

  function automatic logic [StateWidth-1:0] keccak_round(logic [StateWidth-1:0] st,
                                                        logic [LaneWidth-1:0] rc);
    logic [LaneWidth-1:0] a [LaneCount];
    logic [LaneWidth-1:0] b [LaneCount];
    logic [LaneWidth-1:0] col [5];
    logic [LaneWidth-1:0] dx [5];
    logic [StateWidth-1:0] res;
    int xm, xp, x2;
    for (int n = 0; n < LaneCount; n++) begin
      a[n] = st[LaneWidth*n +: LaneWidth];
    end
    // theta
    for (int x = 0; x < 5; x++) begin
      col[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
    end
    for (int x = 0; x < 5; x++) begin
      xm = (x == 0) ? 4 : x - 1;
      xp = (x == 4) ? 0 : x + 1;
      dx[x] = col[xm] ^ rotl4(col[xp], 2'd1);
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        a[x+5*y] = a[x+5*y] ^ dx[x];
      end
    end
    // rho
    for (int n = 0; n < LaneCount; n++) begin
      a[n] = rotl4(a[n], RhoOff[n]);
    end
    // pi
    for (int n = 0; n < LaneCount; n++) begin
      b[n] = a[PiSrc[n]];
    end
    // chi
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        xp = (x == 4) ? 0 : x + 1;
        x2 = (x >= 3) ? x - 3 : x + 2;
        a[x+5*y] = b[x+5*y] ^ (~b[xp+5*y] & b[x2+5*y]);
      end
    end
    // iota
    a[0] = a[0] ^ rc;
    for (int n = 0; n < LaneCount; n++) begin
      res[LaneWidth*n +: LaneWidth] = a[n];
    end
    return res;
  endfunction

endpackage

[src/kpra_front.sv]
module kpra_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kpra_pkg::in_word_t in_word_i,
  input  logic               pop_i,
  output kpra_pkg::head_t    head_o
);

  kpra_pkg::in_word_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // store the whole input word, block and fresh flag, at the write pointer
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_word_i;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.word  = mem_q[rd_ptr_q];

endmodule

[src/kpra_back.sv]
module kpra_back #(
  parameter int unsigned Rounds = kpra_pkg::Rounds
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kpra_pkg::head_t      head_i,
  input  kpra_pkg::rc_cfg_t    rc_cfg_i,
  output kpra_pkg::back_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kpra_pkg::out_word_t  out_word_o
);

  localparam int unsigned IdxW = kpra_pkg::RoundIdxW;
  localparam int unsigned SW   = kpra_pkg::StateWidth;
  localparam logic [IdxW-1:0] FirstRound = IdxW'(kpra_pkg::NumRoundIdx - Rounds);
  localparam logic [IdxW-1:0] EndRound   = IdxW'(kpra_pkg::NumRoundIdx);

  logic [SW-1:0]   sponge_q, sponge_d;
  logic            busy_q, busy_d;
  logic [IdxW-1:0] round_q, round_d;
  logic            out_valid_q, out_valid_d;
  kpra_pkg::out_word_t out_word_q;

  logic [SW-1:0]   absorbed, src, mid, after;
  logic [IdxW-1:0] idx, idx_next;
  logic [kpra_pkg::LaneWidth-1:0] rc_a, rc_b;
  logic            last, out_free, go;

  always_comb begin
    absorbed = (head_i.word.fresh ? '0 : sponge_q)
             ^ {{(SW-kpra_pkg::BlockWidth){1'b0}}, head_i.word.rate_block};
    src      = busy_q ? sponge_q : absorbed;
    idx      = busy_q ? round_q : FirstRound;
    idx_next = idx + IdxW'(1);
    rc_a     = (idx == kpra_pkg::SpecialRound) ? rc_cfg_i.round14 : rc_cfg_i.other;
    rc_b     = (idx_next == kpra_pkg::SpecialRound) ? rc_cfg_i.round14 : rc_cfg_i.other;
    mid      = kpra_pkg::keccak_round(src, rc_a);
    // second round of the step only while round indices remain
    after    = (idx == kpra_pkg::LastRound) ? mid : kpra_pkg::keccak_round(mid, rc_b);
    last     = (idx + IdxW'(2)) >= EndRound;
    out_free = !out_valid_q || out_ready_i;
    go       = (busy_q || head_i.valid) && (!last || out_free);

    sponge_d    = go ? after : sponge_q;
    busy_d      = busy_q;
    round_d     = round_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (go) begin
      busy_d  = !last;
      round_d = idx + IdxW'(2);
      if (last) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sponge_q    <= '0;
      busy_q      <= 1'b0;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sponge_q    <= sponge_d;
      busy_q      <= busy_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && last) begin
      out_word_q <= after;
    end
  end

  assign stat_o.pop  = go && !busy_q;
  assign stat_o.busy = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[src/keccak_p100_reduced_absorb.sv]
// channel   dir  handshake                  payload
// in        in   in_valid_i / in_ready_o    in_word_i   (rate_block, fresh)
// out       out  out_valid_o / out_ready_i  out_word_o  (state_high, state_low)
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// the back stage works on the held state and takes no new word while busy; its
// datapath does two rounds per cycle, so with the default two rounds it takes one
// word per cycle unless out_ready_i stalls, and sets out_valid_o in the next cycle
// reset clears the state to zero and loads the round constants 9 and 3
// a two-entry queue lets input words keep coming while a result waits on out_ready_i
module keccak_p100_reduced_absorb #(
  parameter int unsigned Rounds = kpra_pkg::Rounds
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  kpra_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output kpra_pkg::out_word_t            out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kpra_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [kpra_pkg::LaneWidth-1:0] cfg_data_i
);

  kpra_pkg::head_t      head;
  kpra_pkg::back_stat_t stat;
  kpra_pkg::rc_cfg_t    rc_cfg_q, rc_cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    rc_cfg_d = rc_cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kpra_pkg::CfgRound14:    rc_cfg_d.round14 = cfg_data_i;
        kpra_pkg::CfgOtherRound: rc_cfg_d.other   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_cfg_q.round14 <= kpra_pkg::Round14Reset;
      rc_cfg_q.other   <= kpra_pkg::OtherRoundReset;
    end else begin
      rc_cfg_q <= rc_cfg_d;
    end
  end

  kpra_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .pop_i      (stat.pop),
    .head_o     (head)
  );

  kpra_back #(
    .Rounds (Rounds)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .rc_cfg_i    (rc_cfg_q),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTHESIS
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pop |-> head.valid)
    else $error("back took a word from an empty queue");

  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> head.valid)
    else $error("queue full but no head word");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(stat.pop || stat.busy))
    else $error("result appeared without a word in work");
`endif

endmodule

[tb/sv/tb_keccak_p100_reduced_absorb.sv]
`timescale 1ns / 100ps

module tb_keccak_p100_reduced_absorb;

  localparam int NRounds     = kpra_pkg::Rounds;
  localparam int RoundIdxEnd = 16;
  localparam int Round14Idx  = 14;
  localparam int PhaseItems  = 230;
  localparam int NumPhases   = 8;
  localparam int QuietLimit  = 2000;
  localparam int MaxPrints   = 40;
  localparam int HoldCycles  = 80;
  localparam int NumDirected = 15;

  // register indexes the block does not decode
  localparam logic [kpra_pkg::CfgIndexW-1:0] CfgSpareA = 2'd2;
  localparam logic [kpra_pkg::CfgIndexW-1:0] CfgSpareB = 2'd3;

  typedef struct packed {
    logic        typed;
    logic        fresh;
    logic [29:0] blk;
    logic [35:0] hi;
    logic [63:0] lo;
  } dir_row_t;

  // zero block from reset constants: lane 0 gets 9 in round 14, the rest follows by hand
  localparam dir_row_t DirRows [NumDirected] = '{
    '{1'b1, 1'b0, 30'h0000_0000, 36'h6_0F09_0960, 64'hF000_3333_000C_1C9A},
    '{1'b0, 1'b0, 30'h3FFF_FFFF, 36'h0, 64'h0},
    '{1'b0, 1'b1, 30'h3FFF_FFFF, 36'h0, 64'h0},
    '{1'b1, 1'b1, 30'h0000_0000, 36'h6_0F09_0960, 64'hF000_3333_000C_1C9A},
    '{1'b0, 1'b0, 30'h0000_0001, 36'h0, 64'h0},
    '{1'b0, 1'b0, 30'h2000_0000, 36'h0, 64'h0},
    '{1'b0, 1'b1, 30'h2AAA_AAAA, 36'h0, 64'h0},
    '{1'b0, 1'b0, 30'h1555_5555, 36'h0, 64'h0},
    '{1'b0, 1'b0, 30'h3FFF_FFFF, 36'h0, 64'h0},
    '{1'b0, 1'b1, 30'h0000_000F, 36'h0, 64'h0},
    '{1'b0, 1'b0, 30'h3000_0000, 36'h0, 64'h0},
    '{1'b0, 1'b0, 30'h0F0F_0F0F, 36'h0, 64'h0},
    '{1'b0, 1'b0, 30'h3C3C_3C3C, 36'h0, 64'h0},
    '{1'b0, 1'b1, 30'h1234_5678, 36'h0, 64'h0},
    '{1'b0, 1'b0, 30'h0000_0000, 36'h0, 64'h0}
  };

  localparam logic [3:0] PhaseR14   [4] = '{4'h0, 4'hF, 4'hB, 4'h0};
  localparam logic [3:0] PhaseOther [4] = '{4'h0, 4'hF, 4'h0, 4'hF};

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  kpra_pkg::in_word_t             in_word_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  kpra_pkg::out_word_t            out_word_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [kpra_pkg::CfgIndexW-1:0] cfg_index_i;
  logic [kpra_pkg::LaneWidth-1:0] cfg_data_i;

  keccak_p100_reduced_absorb DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // predicted sponge state and round constants
  logic [3:0] lanes [25];
  logic [3:0] rc14;
  logic [3:0] rc_other;

  kpra_pkg::out_word_t pending_states [$];

  int blocks_sent  = 0;
  int fresh_count  = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int cfg_writes   = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  function automatic logic [3:0] rot_nib(logic [3:0] v, int d);
    int s;
    s = d % 4;
    if (s == 0) return v;
    return (v << s) | (v >> (4 - s));
  endfunction

  function automatic void sponge_round(int ridx);
    logic [3:0] col [5];
    logic [3:0] tmp [25];
    logic [3:0] row [5];
    logic [3:0] d;
    int x, y, t, ny, amt;
    for (x = 0; x < 5; x++) begin
      col[x] = '0;
      for (y = 0; y < 5; y++) col[x] ^= lanes[x + 5 * y];
    end
    for (x = 0; x < 5; x++) begin
      d = col[(x + 4) % 5] ^ rot_nib(col[(x + 1) % 5], 1);
      for (y = 0; y < 5; y++) lanes[x + 5 * y] ^= d;
    end
    // rho walks the lanes along the (x,y) -> (y,2x+3y) orbit
    x = 1;
    y = 0;
    for (t = 0; t < 24; t++) begin
      amt = ((t + 1) * (t + 2) / 2) % 4;
      lanes[x + 5 * y] = rot_nib(lanes[x + 5 * y], amt);
      ny = (2 * x + 3 * y) % 5;
      x = y;
      y = ny;
    end
    for (x = 0; x < 5; x++) begin
      for (y = 0; y < 5; y++) tmp[x + 5 * y] = lanes[(x + 3 * y) % 5 + 5 * x];
    end
    for (y = 0; y < 5; y++) begin
      for (x = 0; x < 5; x++) begin
        row[x] = tmp[x + 5 * y] ^ (~tmp[(x + 1) % 5 + 5 * y] & tmp[(x + 2) % 5 + 5 * y]);
      end
      for (x = 0; x < 5; x++) lanes[x + 5 * y] = row[x];
    end
    lanes[0] ^= (ridx == Round14Idx) ? rc14 : rc_other;
  endfunction

  function automatic kpra_pkg::out_word_t absorb_block(kpra_pkg::in_word_t w);
    kpra_pkg::out_word_t st;
    logic [31:0] blk32;
    blk32 = {2'b00, w.rate_block};
    if (w.fresh) begin
      for (int n = 0; n < 25; n++) lanes[n] = '0;
    end
    for (int j = 0; j < 8; j++) lanes[j] ^= blk32[4 * j +: 4];
    for (int r = RoundIdxEnd - NRounds; r < RoundIdxEnd; r++) sponge_round(r);
    for (int j = 0; j < 16; j++) st.state_low[4 * j +: 4] = lanes[j];
    for (int j = 16; j < 25; j++) st.state_high[4 * (j - 16) +: 4] = lanes[j];
    return st;
  endfunction

  function automatic void apply_reg(logic [kpra_pkg::CfgIndexW-1:0] idx, logic [3:0] val);
    if (idx == kpra_pkg::CfgRound14) rc14 = val;
    else if (idx == kpra_pkg::CfgOtherRound) rc_other = val;
  endfunction

  function automatic kpra_pkg::in_word_t random_block();
    kpra_pkg::in_word_t w;
    int pick;
    pick = $urandom_range(0, 9);
    unique case (pick)
      0: w.rate_block = '0;
      1: w.rate_block = '1;
      default: w.rate_block = 30'($urandom);
    endcase
    // mostly runs of continued absorbs, with a fresh start now and then
    w.fresh = ($urandom_range(0, 5) == 0);
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= MaxPrints) begin
      $display("mismatch at state %0d: %s got %h want %h", results_seen, what, got, want);
    end
  endtask

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_block(input kpra_pkg::in_word_t w, input logic typed,
                            input kpra_pkg::out_word_t typed_state);
    kpra_pkg::out_word_t st;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    st = absorb_block(w);
    pending_states.push_back(typed ? typed_state : st);
    blocks_sent++;
    if (w.fresh) fresh_count++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [kpra_pkg::CfgIndexW-1:0] idx, input logic [3:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // drain all results, then let the two-stage pipe go quiet
  task automatic settle();
    while (pending_states.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : output_side
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_states
    kpra_pkg::out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_states.size() == 0) begin
        report_mismatch("unexpected state_low", out_word_o.state_low, '0);
      end else begin
        want = pending_states.pop_front();
        if (out_word_o.state_low !== want.state_low) begin
          report_mismatch("state_low", out_word_o.state_low, want.state_low);
        end
        if (out_word_o.state_high !== want.state_high) begin
          report_mismatch("state_high", 64'(out_word_o.state_high), 64'(want.state_high));
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    kpra_pkg::in_word_t  w;
    kpra_pkg::out_word_t typed_state;
    logic [3:0]          r14;
    logic [3:0]          ro;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    for (int n = 0; n < 25; n++) lanes[n] = '0;
    rc14     = 4'h9;
    rc_other = 4'h3;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      w.rate_block           = DirRows[i].blk;
      w.fresh                = DirRows[i].fresh;
      typed_state.state_low  = DirRows[i].lo;
      typed_state.state_high = DirRows[i].hi;
      send_block(w, DirRows[i].typed, typed_state);
    end
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      gap_pct   = 0;
      stall_pct = 0;
      settle();
      if (ph < 4) begin
        r14 = PhaseR14[ph];
        ro  = PhaseOther[ph];
      end else begin
        r14 = 4'($urandom_range(0, 15));
        ro  = 4'($urandom_range(0, 15));
      end
      write_reg(kpra_pkg::CfgRound14, r14);
      write_reg(kpra_pkg::CfgOtherRound, ro);
      // undecoded index must leave both constants alone
      if (ph % 2 == 0) begin
        write_reg((ph % 4 == 0) ? CfgSpareA : CfgSpareB, 4'($urandom_range(0, 15)));
      end
      cfg_valid_i <= 1'b0;

      unique case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 56; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 56; end
        default: begin gap_pct = 11; stall_pct = 11; end
      endcase
      // long output hold-off while input keeps coming, fills the queue
      if (ph == 4) hold_left = HoldCycles;

      for (int i = 0; i < PhaseItems; i++) send_block(random_block(), 1'b0, '0);
      in_valid_i <= 1'b0;
    end

    gap_pct   = 0;
    stall_pct = 0;
    while (pending_states.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("absorbed %0d blocks (%0d fresh), checked %0d states, %0d register writes",
             blocks_sent, fresh_count, results_seen, cfg_writes);
    $display("phases: free flow, input gaps, output stalls, both, one long output hold-off");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[keccak_p100_reduced_absorb.f]
src/kpra_pkg.sv
src/kpra_front.sv
src/kpra_back.sv
src/keccak_p100_reduced_absorb.sv
tb/sv/tb_keccak_p100_reduced_absorb.sv
